// ===== hw/rtl/dhl_pkg.sv =====
// shared constants and tables for the dh link transform pipeline
`timescale 1ns / 1ps
package dhl_pkg;

	localparam int CORDIC_STAGES = 18;
	localparam int CORDIC_N = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int RED_STEPS = 13;
	localparam int SC_LAT = RED_STEPS + CORDIC_N + 4;

	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic [45:0] TWO_PI_U = 46'd6746518852;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	localparam logic [2:0] REG_PRISMATIC = 3'd0;
	localparam logic [2:0] REG_OFFSET = 3'd1;
	localparam logic [2:0] REG_LOWER = 3'd2;
	localparam logic [2:0] REG_UPPER = 3'd3;
	localparam logic [2:0] REG_OTHER = 3'd4;
	localparam logic [2:0] REG_LENGTH = 3'd5;
	localparam logic [2:0] REG_TWIST = 3'd6;

	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] r;
		unique case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			10: r = 34'sd1048576;
			11: r = 34'sd524288;
			12: r = 34'sd262144;
			13: r = 34'sd131072;
			14: r = 34'sd65536;
			15: r = 34'sd32768;
			16: r = 34'sd16384;
			17: r = 34'sd8192;
			18: r = 34'sd4096;
			19: r = 34'sd2048;
			20: r = 34'sd1024;
			21: r = 34'sd512;
			22: r = 34'sd256;
			23: r = 34'sd128;
			24: r = 34'sd64;
			25: r = 34'sd32;
			26: r = 34'sd16;
			27: r = 34'sd8;
			28: r = 34'sd4;
			29: r = 34'sd2;
			30: r = 34'sd1;
			default: r = 34'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/dhl_front.sv =====
// offset add with saturation, limit clamp and dh variable selection
`timescale 1ns / 1ps
module dhl_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic signed [31:0] pos,
	input  logic               prismatic,
	input  logic signed [31:0] offset,
	input  logic signed [31:0] lower,
	input  logic signed [31:0] upper,
	input  logic signed [31:0] other,
	output logic               vout,
	output logic signed [31:0] q,
	output logic signed [31:0] theta,
	output logic signed [31:0] d
);

	logic signed [32:0] sum;
	logic signed [31:0] sat_sum;
	logic signed [31:0] sum_s1;
	logic               v_s1;
	logic signed [31:0] clamped;
	logic signed [31:0] q_s2;
	logic signed [31:0] theta_s2;
	logic signed [31:0] d_s2;
	logic               v_s2;

	always_comb begin
		sum = 33'(pos) + 33'(offset);
		if (sum > 33'sd2147483647) begin
			sat_sum = 32'sh7fffffff;
		end else if (sum < -33'sd2147483648) begin
			sat_sum = 32'sh80000000;
		end else begin
			sat_sum = sum[31:0];
		end
	end

	always_comb begin
		clamped = sum_s1;
		if (lower < upper) begin
			if (sum_s1 < lower) begin
				clamped = lower;
			end else if (sum_s1 > upper) begin
				clamped = upper;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1 <= sat_sum;
			q_s2 <= clamped;
			theta_s2 <= prismatic ? other : clamped;
			d_s2 <= prismatic ? clamped : other;
		end
	end

	assign vout = v_s2;
	assign q = q_s2;
	assign theta = theta_s2;
	assign d = d_s2;

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vin) |=> v_s1) else $error("front valid lost");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(q_s2)) else $error("front output moved while held");

endmodule

// ===== hw/rtl/dhl_sincos.sv =====
// pipelined angle reduction and rotation cordic giving sine and cosine in q16.16
`timescale 1ns / 1ps
module dhl_sincos (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic signed [31:0] ang,
	output logic               vout,
	output logic signed [31:0] s,
	output logic signed [31:0] c
);

	localparam int NR = dhl_pkg::RED_STEPS;
	localparam int NC = dhl_pkg::CORDIC_N;

	logic [45:0]        red_mag_s [0:NR];
	logic               red_neg_s [0:NR];
	logic               red_v_s [0:NR];
	logic [31:0]        abs_ang;
	logic signed [35:0] z_signed;
	logic signed [35:0] z_wrap;
	logic signed [35:0] wrap_s1;
	logic               wrap_v_s1;
	logic signed [35:0] z_fold;
	logic               fold_flip;
	logic signed [33:0] x_s [0:NC];
	logic signed [33:0] y_s [0:NC];
	logic signed [33:0] z_s [0:NC];
	logic               flip_s [0:NC];
	logic               v_s [0:NC];
	logic signed [33:0] x_fin;
	logic signed [33:0] y_fin;
	logic signed [33:0] c_rnd;
	logic signed [33:0] s_rnd;
	logic signed [31:0] c_out_s1;
	logic signed [31:0] s_out_s1;
	logic               out_v_s1;

	assign abs_ang = ang[31] ? 32'(-{ang[31], ang}) : 32'(ang);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_v_s[0] <= 1'b0;
		end else if (en) begin
			red_v_s[0] <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_mag_s[0] <= {abs_ang, 14'd0};
			red_neg_s[0] <= ang[31];
		end
	end

	for (genvar k = 0; k < NR; k++) begin : g_red
		localparam logic [45:0] STEP = dhl_pkg::TWO_PI_U << (NR - 1 - k);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				red_v_s[k + 1] <= 1'b0;
			end else if (en) begin
				red_v_s[k + 1] <= red_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				red_mag_s[k + 1] <= (red_mag_s[k] >= STEP) ? red_mag_s[k] - STEP : red_mag_s[k];
				red_neg_s[k + 1] <= red_neg_s[k];
			end
		end
	end

	always_comb begin
		z_signed = red_neg_s[NR] ? -$signed({3'b000, red_mag_s[NR][32:0]})
			: $signed({3'b000, red_mag_s[NR][32:0]});
		z_wrap = z_signed;
		if (z_signed > dhl_pkg::PI_Q30) begin
			z_wrap = z_signed - dhl_pkg::TWO_PI_Q30;
		end else if (z_signed < -dhl_pkg::PI_Q30) begin
			z_wrap = z_signed + dhl_pkg::TWO_PI_Q30;
		end
	end

	always_comb begin
		z_fold = wrap_s1;
		fold_flip = 1'b0;
		if (wrap_s1 > dhl_pkg::HALF_PI_Q30) begin
			z_fold = wrap_s1 - dhl_pkg::PI_Q30;
			fold_flip = 1'b1;
		end else if (wrap_s1 < -dhl_pkg::HALF_PI_Q30) begin
			z_fold = wrap_s1 + dhl_pkg::PI_Q30;
			fold_flip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_v_s1 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			wrap_v_s1 <= red_v_s[NR];
			v_s[0] <= wrap_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wrap_s1 <= z_wrap;
			x_s[0] <= dhl_pkg::GAIN_Q30;
			y_s[0] <= 34'sd0;
			z_s[0] <= z_fold[33:0];
			flip_s[0] <= fold_flip;
		end
	end

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		localparam logic signed [33:0] ATAN = dhl_pkg::atan_q30(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i + 1] <= 1'b0;
			end else if (en) begin
				v_s[i + 1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][33]) begin
					x_s[i + 1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i + 1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i + 1] <= z_s[i] - ATAN;
				end else begin
					x_s[i + 1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i + 1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i + 1] <= z_s[i] + ATAN;
				end
				flip_s[i + 1] <= flip_s[i];
			end
		end
	end

	always_comb begin
		x_fin = flip_s[NC] ? -x_s[NC] : x_s[NC];
		y_fin = flip_s[NC] ? -y_s[NC] : y_s[NC];
		c_rnd = (x_fin + 34'sd8192) >>> 14;
		s_rnd = (y_fin + 34'sd8192) >>> 14;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s1 <= 1'b0;
		end else if (en) begin
			out_v_s1 <= v_s[NC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_out_s1 <= c_rnd[31:0];
			s_out_s1 <= s_rnd[31:0];
		end
	end

	assign vout = out_v_s1;
	assign s = s_out_s1;
	assign c = c_out_s1;

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		red_v_s[NR] |-> (red_mag_s[NR] < dhl_pkg::TWO_PI_U))
		else $error("reduction remainder out of range");
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[0] |-> (36'(z_s[0]) <= dhl_pkg::HALF_PI_Q30 && 36'(z_s[0]) >= -dhl_pkg::HALF_PI_Q30))
		else $error("folded angle out of range");

endmodule

// ===== hw/rtl/dhl_product.sv =====
// transform entry products with rounding, negation and saturation
`timescale 1ns / 1ps
module dhl_product (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vin,
	input  logic signed [31:0] st,
	input  logic signed [31:0] ct,
	input  logic signed [31:0] sa,
	input  logic signed [31:0] ca,
	input  logic signed [31:0] a,
	input  logic signed [31:0] q,
	input  logic signed [31:0] d,
	output logic               vout,
	output logic signed [31:0] joint_used,
	output logic signed [31:0] t00,
	output logic signed [31:0] t01,
	output logic signed [31:0] t02,
	output logic signed [31:0] t03,
	output logic signed [31:0] t10,
	output logic signed [31:0] t11,
	output logic signed [31:0] t12,
	output logic signed [31:0] t13,
	output logic signed [31:0] t21,
	output logic signed [31:0] t22,
	output logic signed [31:0] t23
);

	function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p, input logic neg);
		logic signed [63:0] r;
		logic signed [64:0] v;
		logic signed [31:0] o;
		r = (p + 64'sd32768) >>> 16;
		v = neg ? -65'(r) : 65'(r);
		if (v > 65'sd2147483647) begin
			o = 32'sh7fffffff;
		end else if (v < -65'sd2147483648) begin
			o = 32'sh80000000;
		end else begin
			o = v[31:0];
		end
		return o;
	endfunction

	logic signed [63:0] st_ca_s1, st_sa_s1, a_ct_s1, ct_ca_s1, ct_sa_s1, a_st_s1;
	logic signed [31:0] st_s1, ct_s1, sa_s1, ca_s1, q_s1, d_s1;
	logic               v_s1;
	logic               v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_ca_s1 <= 64'(st) * 64'(ca);
			st_sa_s1 <= 64'(st) * 64'(sa);
			a_ct_s1 <= 64'(a) * 64'(ct);
			ct_ca_s1 <= 64'(ct) * 64'(ca);
			ct_sa_s1 <= 64'(ct) * 64'(sa);
			a_st_s1 <= 64'(a) * 64'(st);
			st_s1 <= st;
			ct_s1 <= ct;
			sa_s1 <= sa;
			ca_s1 <= ca;
			q_s1 <= q;
			d_s1 <= d;
			joint_used <= q_s1;
			t00 <= ct_s1;
			t01 <= rnd_sat(st_ca_s1, 1'b1);
			t02 <= rnd_sat(st_sa_s1, 1'b0);
			t03 <= rnd_sat(a_ct_s1, 1'b0);
			t10 <= st_s1;
			t11 <= rnd_sat(ct_ca_s1, 1'b0);
			t12 <= rnd_sat(ct_sa_s1, 1'b1);
			t13 <= rnd_sat(a_st_s1, 1'b0);
			t21 <= sa_s1;
			t22 <= ca_s1;
			t23 <= d_s1;
		end
	end

	assign vout = v_s2;

	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s1) |=> v_s2) else $error("product valid lost");

endmodule

// ===== hw/rtl/dh_link_transform_top.sv =====
// dh link transform: offset and clamp, cordic sine and cosine, 3x4 transform rows
//  channel | direction | handshake           | payload
//  in      | input     | in_valid, in_stall   | joint_position
//  out     | output    | out_valid, out_stall | joint_used, t00..t23
//  cfg     | input     | cfg_write            | cfg_index, cfg_data
// one transaction per cycle sustained, except while the pipeline holds on out_stall
// latency is set by the 13 step modulo reduction and the cordic stage chain
// the whole pipeline holds while out_valid is high and out_stall is high
// arst_n clears all valid bits and config registers
`timescale 1ns / 1ps
module dh_link_transform_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] joint_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] joint_used,
	output logic signed [31:0] t00,
	output logic signed [31:0] t01,
	output logic signed [31:0] t02,
	output logic signed [31:0] t03,
	output logic signed [31:0] t10,
	output logic signed [31:0] t11,
	output logic signed [31:0] t12,
	output logic signed [31:0] t13,
	output logic signed [31:0] t21,
	output logic signed [31:0] t22,
	output logic signed [31:0] t23,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int LS = dhl_pkg::SC_LAT;

	logic               prismatic_q;
	logic signed [31:0] offset_q, lower_q, upper_q, other_q, length_q, twist_q;
	logic               en;
	logic               v_front;
	logic signed [31:0] q_front, theta_front, d_front;
	logic               v_th, v_al;
	logic signed [31:0] st, ct, sa, ca;
	logic signed [31:0] q_dly_s [0:LS-1];
	logic signed [31:0] d_dly_s [0:LS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prismatic_q <= 1'b0;
			offset_q <= '0;
			lower_q <= '0;
			upper_q <= '0;
			other_q <= '0;
			length_q <= '0;
			twist_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dhl_pkg::REG_PRISMATIC: prismatic_q <= cfg_data[0];
				dhl_pkg::REG_OFFSET: offset_q <= cfg_data;
				dhl_pkg::REG_LOWER: lower_q <= cfg_data;
				dhl_pkg::REG_UPPER: upper_q <= cfg_data;
				dhl_pkg::REG_OTHER: other_q <= cfg_data;
				dhl_pkg::REG_LENGTH: length_q <= cfg_data;
				dhl_pkg::REG_TWIST: twist_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	dhl_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(in_valid), .pos(joint_position),
		.prismatic(prismatic_q), .offset(offset_q), .lower(lower_q), .upper(upper_q),
		.other(other_q), .vout(v_front), .q(q_front), .theta(theta_front), .d(d_front)
	);

	dhl_sincos u_theta (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_front), .ang(theta_front),
		.vout(v_th), .s(st), .c(ct)
	);

	dhl_sincos u_alpha (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_front), .ang(twist_q),
		.vout(v_al), .s(sa), .c(ca)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			q_dly_s[0] <= q_front;
			d_dly_s[0] <= d_front;
			for (int k = 1; k < LS; k++) begin
				q_dly_s[k] <= q_dly_s[k - 1];
				d_dly_s[k] <= d_dly_s[k - 1];
			end
		end
	end

	dhl_product u_product (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_th && v_al),
		.st(st), .ct(ct), .sa(sa), .ca(ca), .a(length_q),
		.q(q_dly_s[LS-1]), .d(d_dly_s[LS-1]), .vout(out_valid),
		.joint_used(joint_used), .t00(t00), .t01(t01), .t02(t02), .t03(t03),
		.t10(t10), .t11(t11), .t12(t12), .t13(t13), .t21(t21), .t22(t22), .t23(t23)
	);

	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		v_th == v_al) else $error("sine lanes out of step");

endmodule

// ===== bench/tb_dh_link_transform_top.sv =====
// testbench for the dh link transform: predicts each transaction and checks every result field
`timescale 1ns / 1ps
module tb_dh_link_transform_top;

	localparam int PIPE_LAT = 2 + dhl_pkg::SC_LAT + 2;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic signed [31:0] jused, r00, r01, r02, r03, r10, r11, r12, r13, r21, r22, r23;
	} xform_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] joint_position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] joint_used, t00, t01, t02, t03, t10, t11, t12, t13, t21, t22, t23;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = dhl_pkg::REG_PRISMATIC;
	logic [31:0] cfg_data = '0;

	logic m_prismatic;
	logic signed [31:0] m_offset, m_lower, m_upper, m_other, m_length, m_twist;

	logic signed [31:0] pending_positions[$];
	xform_t expected_xforms[$];
	int mismatches = 0;
	int accepted_in = 0;
	int accepted_out = 0;
	int idle_cycles = 0;
	int in_gap = 0;
	int out_gap = 0;

	dh_link_transform_top dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fix_mul(longint a, longint b);
		return fshr(a * b + 32768, 16);
	endfunction

	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint two_pi, z, x, y, nx;
		bit flip;
		two_pi = 2 * longint'(dhl_pkg::PI_Q30);
		z = (ang * 16384) % two_pi;
		x = longint'(dhl_pkg::GAIN_Q30);
		y = 0;
		flip = 1'b0;
		if (z > longint'(dhl_pkg::PI_Q30)) z -= two_pi;
		else if (z < -longint'(dhl_pkg::PI_Q30)) z += two_pi;
		if (z > longint'(dhl_pkg::HALF_PI_Q30)) begin
			z -= longint'(dhl_pkg::PI_Q30);
			flip = 1'b1;
		end else if (z < -longint'(dhl_pkg::HALF_PI_Q30)) begin
			z += longint'(dhl_pkg::PI_Q30);
			flip = 1'b1;
		end
		for (int i = 0; i < dhl_pkg::CORDIC_N; i++) begin
			if (z >= 0) begin
				nx = x - fshr(y, i);
				y = y + fshr(x, i);
				z -= longint'(dhl_pkg::atan_q30(i));
			end else begin
				nx = x + fshr(y, i);
				y = y - fshr(x, i);
				z += longint'(dhl_pkg::atan_q30(i));
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		c = fshr(x + 8192, 14);
		s = fshr(y + 8192, 14);
	endfunction

	function automatic xform_t link_transform(logic signed [31:0] pos);
		xform_t r;
		longint q, th, d, st, ct, sa, ca;
		q = sat(longint'(pos) + longint'(m_offset));
		if (m_lower < m_upper) begin
			if (q < m_lower) q = longint'(m_lower);
			else if (q > m_upper) q = longint'(m_upper);
		end
		th = m_prismatic ? longint'(m_other) : q;
		d = m_prismatic ? q : longint'(m_other);
		sin_cos(th, st, ct);
		sin_cos(longint'(m_twist), sa, ca);
		r.jused = 32'(q);
		r.r00 = 32'(sat(ct));
		r.r01 = 32'(sat(-fix_mul(st, ca)));
		r.r02 = 32'(sat(fix_mul(st, sa)));
		r.r03 = 32'(sat(fix_mul(longint'(m_length), ct)));
		r.r10 = 32'(sat(st));
		r.r11 = 32'(sat(fix_mul(ct, ca)));
		r.r12 = 32'(sat(-fix_mul(ct, sa)));
		r.r13 = 32'(sat(fix_mul(longint'(m_length), st)));
		r.r21 = 32'(sat(sa));
		r.r22 = 32'(sat(ca));
		r.r23 = 32'(d);
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [31:0] rand_word();
		unique case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 32'h0006_4000)) - 32'sh0003_2000;
			3: return $signed($urandom_range(0, 32'h0000_ffff)) - 32'sh0000_8000;
			default: return $urandom;
		endcase
	endfunction

	// driver
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_xforms.push_back(link_transform(joint_position));
			accepted_in++;
		end
		if (in_valid && in_stall) begin
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 1'b0;
		end else if (pending_positions.size() > 0) begin
			joint_position <= pending_positions.pop_front();
			in_valid <= 1'b1;
			in_gap <= pick_gap();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		xform_t got, exp_x;
		if (out_valid && !out_stall) begin
			accepted_out++;
			got = '{joint_used, t00, t01, t02, t03, t10, t11, t12, t13, t21, t22, t23};
			if (expected_xforms.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction: %h", got);
			end else begin
				exp_x = expected_xforms.pop_front();
				if (got !== exp_x) begin
					mismatches++;
					if (mismatches <= 10)
						$display("transaction %0d\n  expected %h\n  actual   %h",
							accepted_out, exp_x, got);
				end
			end
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			out_gap <= pick_gap();
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n ||
			(pending_positions.size() == 0 && expected_xforms.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout");
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		unique case (idx)
			dhl_pkg::REG_PRISMATIC: m_prismatic = val[0];
			dhl_pkg::REG_OFFSET: m_offset = val;
			dhl_pkg::REG_LOWER: m_lower = val;
			dhl_pkg::REG_UPPER: m_upper = val;
			dhl_pkg::REG_OTHER: m_other = val;
			dhl_pkg::REG_LENGTH: m_length = val;
			dhl_pkg::REG_TWIST: m_twist = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_positions.size() > 0 || in_valid || expected_xforms.size() > 0)
			@(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	initial begin
		logic signed [31:0] directed[$];
		m_prismatic = 1'b0;
		{m_offset, m_lower, m_upper, m_other, m_length, m_twist} = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		directed = '{32'sh0, 32'sh7fffffff, 32'sh80000000, 32'sh0001_921f, 32'shfffe_6de1,
			32'sh0003_243f, 32'shfffc_dbc1, 32'sh0000_c90f, 32'sh0006_487f, 32'sh0001_0000,
			32'shffff_0000, 32'sh0000_0001, 32'shffff_ffff, 32'sh5555_aaaa};
		foreach (directed[i]) pending_positions.push_back(directed[i]);
		drain();

		// offset overflow, ordered limits, long link, twist at the edge
		write_reg(dhl_pkg::REG_OFFSET, 32'h7fff_ffff);
		write_reg(dhl_pkg::REG_LOWER, 32'hfffe_0000);
		write_reg(dhl_pkg::REG_UPPER, 32'h0002_0000);
		write_reg(dhl_pkg::REG_LENGTH, 32'h7fff_ffff);
		write_reg(dhl_pkg::REG_TWIST, 32'h0001_921f);
		write_reg(dhl_pkg::REG_OTHER, 32'h8000_0000);
		foreach (directed[i]) pending_positions.push_back(directed[i]);
		drain();

		for (int phase = 0; phase < 8; phase++) begin
			write_reg(dhl_pkg::REG_PRISMATIC, {31'd0, phase[0]});
			write_reg(dhl_pkg::REG_OFFSET, (phase == 3) ? 32'h8000_0000 : rand_word());
			write_reg(dhl_pkg::REG_LOWER, rand_word());
			write_reg(dhl_pkg::REG_UPPER, (phase == 5) ? 32'h7fff_ffff : rand_word());
			write_reg(dhl_pkg::REG_OTHER, rand_word());
			write_reg(dhl_pkg::REG_LENGTH, (phase == 6) ? 32'h8000_0000 : rand_word());
			write_reg(dhl_pkg::REG_TWIST, rand_word());
			for (int k = 0; k < 56; k++) pending_positions.push_back(rand_word());
			drain();
		end

		$display("%0d transactions in, %0d out, over revolute and prismatic settings",
			accepted_in, accepted_out);
		if (mismatches == 0 && expected_xforms.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== dh_link_transform_top.f =====
hw/rtl/dhl_pkg.sv
hw/rtl/dhl_front.sv
hw/rtl/dhl_sincos.sv
hw/rtl/dhl_product.sv
hw/rtl/dh_link_transform_top.sv
bench/tb_dh_link_transform_top.sv
